### hw/rtl/nd_coordinate_address_generator_assert.svh
// Assertion macros for the N-dimensional coordinate address generator.
// Included by the controller and the top level; depends on nothing else.
`ifndef ND_COORDINATE_ADDRESS_GENERATOR_ASSERT_SVH
`define ND_COORDINATE_ADDRESS_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define NDAG_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NDAG_ASSERT_ONEHOT(label, clk, rst_n, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) $onehot(sig)) else $error(msg);
`else
`define NDAG_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define NDAG_ASSERT_ONEHOT(label, clk, rst_n, sig, msg)
`endif
`endif

### hw/rtl/ndag_pkg.sv
// Shared types and constants for the N-dimensional coordinate address generator.
// Used by the controller, the datapath and the top level; depends on nothing.
package ndag_pkg;

	localparam int NumDims    = 4;
	localparam int DimBits    = 16;
	localparam int OffsetBits = 32;
	localparam int NumRegs    = 8;
	localparam int RegIdxBits = 3;
	localparam int AmountBits = 32;
	localparam int OpBits     = 2;

	localparam logic [RegIdxBits-1:0] RegDimSizes  = 3'd0;
	localparam logic [RegIdxBits-1:0] RegBroadcast = 3'd1;

	typedef enum logic [OpBits-1:0] {
		OP_SET     = 2'd0,
		OP_INC     = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture a new item
		logic div_start; // start the division of one dimension
		logic div_step;  // one bit of the running division
		logic digit_wr;  // write the quotient/remainder into the dimension
		logic inc_step;  // one carry step of op 1
		logic mac_step;  // one multiply-accumulate step for the offsets
		logic clear_acc; // reset offset accumulators
		logic done;      // latch wrap and offsets into result
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_last;  // division on its last bit
		logic dim_last;  // current dimension is the top one
		logic inc_done;  // op 1 carry stopped
	} ctrl_sts_t;

endpackage

### hw/rtl/ndag_ctrl.sv
// Controller state machine of the address generator.
// Depends on ndag_pkg and the assertion macro header.
`include "nd_coordinate_address_generator_assert.svh"
module ndag_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  ndag_pkg::op_t         in_op,
	input  logic                  out_busy,
	input  ndag_pkg::ctrl_sts_t   sts,
	output logic                  in_ready,
	output logic                  res_valid,
	output ndag_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIVI  = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_INC   = 6'b001000,
		ST_MAC   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_nxt;
	ndag_pkg::op_t op_q;

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= ndag_pkg::OP_NONE;
		end else begin
			state_q <= state_nxt;
			if (in_valid && in_ready) op_q <= in_op;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (in_op)
						ndag_pkg::OP_SET, ndag_pkg::OP_ADVANCE: state_nxt = ST_DIVI;
						ndag_pkg::OP_INC: state_nxt = ST_INC;
						default: state_nxt = ST_MAC;
					endcase
				end
			end
			ST_DIVI: begin
				cmd.div_start = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					cmd.digit_wr = 1'b1;
					state_nxt = sts.dim_last ? ST_MAC : ST_DIVI;
				end
			end
			ST_INC: begin
				cmd.inc_step = 1'b1;
				if (sts.inc_done || sts.dim_last) state_nxt = ST_MAC;
			end
			ST_MAC: begin
				cmd.mac_step = 1'b1;
				if (sts.dim_last) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_busy) begin
					res_valid = 1'b1;
					cmd.done  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
		if (state_q != ST_MAC && state_nxt == ST_MAC) cmd.clear_acc = 1'b1;
	end

	`NDAG_ASSERT_ONEHOT(a_state_onehot, clk, arst_n, state_q, "state not one-hot")
	`NDAG_ASSERT_IMPL(a_load_idle, clk, arst_n, cmd.load |-> state_q == ST_IDLE, "load outside idle")
	`NDAG_ASSERT_IMPL(a_emit_idle, clk, arst_n, res_valid |=> state_q == ST_IDLE, "emit not back to idle")
	`NDAG_ASSERT_IMPL(a_div_op, clk, arst_n, state_q == ST_DIV |-> (op_q == ndag_pkg::OP_SET || op_q == ndag_pkg::OP_ADVANCE), "division for wrong op")

endmodule

### hw/rtl/ndag_datapath.sv
// Datapath of the address generator: coordinate, bit-serial divider, offset accumulators.
// Depends on ndag_pkg.
module ndag_datapath #(
	parameter int NUM_DIMS    = ndag_pkg::NumDims,
	parameter int DIM_BITS    = ndag_pkg::DimBits,
	parameter int OFFSET_BITS = ndag_pkg::OffsetBits
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ndag_pkg::ctrl_cmd_t         cmd,
	output ndag_pkg::ctrl_sts_t         sts,
	input  ndag_pkg::op_t               in_op,
	input  logic [ndag_pkg::AmountBits-1:0] in_amount,
	input  logic [63:0]                 dim_sizes,
	input  logic [11:0]                 bcast,
	input  logic [63:0]                 strides [6],
	output logic [OFFSET_BITS-1:0]      offset_a,
	output logic [OFFSET_BITS-1:0]      offset_b,
	output logic [OFFSET_BITS-1:0]      offset_c,
	output logic                        wrapped
);

	localparam int DIdxBits = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
	// Running value: amount plus one coordinate digit fits in 33 bits.
	localparam int NBits    = ndag_pkg::AmountBits + 1;
	localparam int BitCntW  = $clog2(NBits);

	logic [DIM_BITS-1:0]  coord_q [NUM_DIMS];
	logic [DIdxBits-1:0]  dim_q;
	logic [NBits-1:0]     n_q;      // dividend, becomes quotient
	logic [DIM_BITS:0]    rem_q;
	logic [BitCntW-1:0]   bit_q;
	logic                 advance_q;
	logic                 wrap_q;
	logic                 inc_carry_q;
	logic [OFFSET_BITS-1:0] acc_q [3];

	// Size of the current dimension, zero or missing reading as one.
	logic [DIM_BITS-1:0] size_cur;
	always_comb begin
		size_cur = DIM_BITS'(1);
		if (32'(dim_q) * DIM_BITS < 64)
			size_cur = DIM_BITS'(dim_sizes >> (32'(dim_q) * DIM_BITS));
		if (size_cur == '0) size_cur = DIM_BITS'(1);
	end

	assign sts.dim_last = (32'(dim_q) == NUM_DIMS - 1);
	assign sts.div_last = (bit_q == '0);

	// Restoring division, one bit a cycle, MSB first.
	logic [DIM_BITS+1:0] trial;
	assign trial = {rem_q, n_q[NBits-1]} - {2'b0, size_cur};

	// Stride and broadcast for the MAC step of tensor t.
	function automatic logic [31:0] stride_sel(input logic [63:0] lo, input logic [63:0] hi,
			input logic [DIdxBits-1:0] d);
		logic [31:0] r;
		r = '0;
		if (32'(d) < 4) begin
			unique case (2'(d))
				2'd0: r = lo[31:0];
				2'd1: r = lo[63:32];
				2'd2: r = hi[31:0];
				default: r = hi[63:32];
			endcase
		end
		return r;
	endfunction

	logic [31:0] prod [3];
	always_comb begin
		for (int t = 0; t < 3; t++) begin
			logic [31:0] c;
			logic        bc;
			bc = (32'(dim_q) < 4) ? bcast[4*t + 32'(dim_q)] : 1'b0;
			c  = bc ? 32'd0 : 32'(coord_q[dim_q]);
			prod[t] = c * stride_sel(strides[2*t], strides[2*t+1], dim_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DIMS; d++) coord_q[d] <= '0;
			dim_q       <= '0;
			wrap_q      <= 1'b0;
			wrapped     <= 1'b0;
			inc_carry_q <= 1'b0;
			advance_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				dim_q       <= '0;
				n_q         <= NBits'(in_amount);
				advance_q   <= (in_op == ndag_pkg::OP_ADVANCE);
				wrap_q      <= 1'b0;
				inc_carry_q <= 1'b1;
			end
			if (cmd.div_start) begin
				n_q   <= advance_q ? n_q + NBits'(coord_q[dim_q]) : n_q;
				rem_q <= '0;
				bit_q <= BitCntW'(NBits - 1);
			end
			if (cmd.div_step) begin
				if (!trial[DIM_BITS+1]) rem_q <= trial[DIM_BITS:0];
				else rem_q <= {rem_q[DIM_BITS-1:0], n_q[NBits-1]};
				n_q   <= {n_q[NBits-2:0], ~trial[DIM_BITS+1]};
				bit_q <= bit_q - 1'b1;
			end
			if (cmd.digit_wr) begin
				coord_q[dim_q] <= (!trial[DIM_BITS+1]) ? trial[DIM_BITS-1:0]
				                                       : {rem_q[DIM_BITS-2:0], n_q[NBits-1]};
				if (sts.dim_last)
					wrap_q <= ({n_q[NBits-2:0], ~trial[DIM_BITS+1]} != '0);
				else
					dim_q <= dim_q + 1'b1;
			end
			if (cmd.inc_step) begin
				if (inc_carry_q) begin
					if (coord_q[dim_q] < size_cur - 1'b1) begin
						coord_q[dim_q] <= coord_q[dim_q] + 1'b1;
						inc_carry_q    <= 1'b0;
					end else begin
						coord_q[dim_q] <= '0;
						if (sts.dim_last) wrap_q <= 1'b1;
					end
				end
				if (!sts.dim_last && !sts.inc_done) dim_q <= dim_q + 1'b1;
			end
			if (cmd.clear_acc) dim_q <= '0;
			if (cmd.mac_step && !sts.dim_last) dim_q <= dim_q + 1'b1;
			if (cmd.done) wrapped <= wrap_q;
		end
	end

	// op 1 stops once a digit took the increment.
	assign sts.inc_done = !inc_carry_q;

	always_ff @(posedge clk) begin
		for (int t = 0; t < 3; t++) begin
			if (cmd.clear_acc) acc_q[t] <= '0;
			else if (cmd.mac_step) acc_q[t] <= acc_q[t] + OFFSET_BITS'(prod[t]);
		end
		if (cmd.done) begin
			offset_a <= acc_q[0];
			offset_b <= acc_q[1];
			offset_c <= acc_q[2];
		end
	end

endmodule

### hw/rtl/nd_coordinate_address_generator.sv
// From input accept to m_tvalid, op 0 and op 2 run, per dimension, a start step and a
// 33-bit division, then one offset step per dimension and an emit step. Op 1 runs carry
// steps up to the digit that takes the increment, or up to the top dimension when it
// wraps, then the offset steps; op 3 runs only the offset steps and the emit step.
// One item is in flight; the next can be accepted as soon as the result is registered.
// Reset (arst_n low, async) clears the coordinate, sizes one, zero strides.
// Depends on ndag_pkg, ndag_ctrl, ndag_datapath and the assertion macro header.
`include "nd_coordinate_address_generator_assert.svh"
module nd_coordinate_address_generator #(
	parameter int NUM_DIMS    = ndag_pkg::NumDims,
	parameter int DIM_BITS    = ndag_pkg::DimBits,
	parameter int OFFSET_BITS = ndag_pkg::OffsetBits
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input beat: tdata = op in bits 1:0, amount in bits 33:2, zero-padded to 40 bits.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	// Result beat: tdata = offset_a, offset_b, offset_c from bit 0 upward; tuser = wrapped.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [3*OFFSET_BITS-1:0] m_tdata,
	output logic        m_tuser,
	// Configuration write.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [ndag_pkg::RegIdxBits-1:0] cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] regs_q [ndag_pkg::NumRegs];
	logic [63:0] strides [6];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ndag_pkg::NumRegs; i++) regs_q[i] <= '0;
			regs_q[ndag_pkg::RegDimSizes] <= 64'h0001_0001_0001_0001;
		end else if (cfg_valid) begin
			if (cfg_index == ndag_pkg::RegBroadcast)
				regs_q[cfg_index] <= {52'd0, cfg_data[11:0]};
			else
				regs_q[cfg_index] <= cfg_data;
		end
	end

	always_comb for (int i = 0; i < 6; i++) strides[i] = regs_q[i + 2];

	ndag_pkg::ctrl_cmd_t cmd;
	ndag_pkg::ctrl_sts_t sts;
	logic res_valid;
	logic [OFFSET_BITS-1:0] off_a, off_b, off_c;
	logic wrap;

	// Result register; the controller holds in emit until it is free.
	logic out_valid_q;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (res_valid) out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	ndag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (ndag_pkg::op_t'(s_tdata[1:0])),
		.out_busy (out_valid_q && !m_tready),
		.sts      (sts),
		.in_ready (s_tready),
		.res_valid(res_valid),
		.cmd      (cmd)
	);

	ndag_datapath #(
		.NUM_DIMS   (NUM_DIMS),
		.DIM_BITS   (DIM_BITS),
		.OFFSET_BITS(OFFSET_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_op    (ndag_pkg::op_t'(s_tdata[1:0])),
		.in_amount(s_tdata[33:2]),
		.dim_sizes(regs_q[ndag_pkg::RegDimSizes]),
		.bcast    (regs_q[ndag_pkg::RegBroadcast][11:0]),
		.strides  (strides),
		.offset_a (off_a),
		.offset_b (off_b),
		.offset_c (off_c),
		.wrapped  (wrap)
	);

	assign m_tdata = {off_c, off_b, off_a};
	assign m_tuser = wrap;

	`NDAG_ASSERT_IMPL(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")
	`NDAG_ASSERT_IMPL(a_no_overwrite, clk, arst_n, res_valid |-> (!out_valid_q || m_tready), "result overwritten")
	`NDAG_ASSERT_IMPL(a_accept_once, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready, "second item accepted")

endmodule

### sim/tb.sv
// Self-checking testbench for nd_coordinate_address_generator.
// Needs ndag_pkg and the RTL of the block; items and configuration are generated here
// and every result beat is checked against a predictor of the coordinate and offsets.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Stride register indexes; the package names only the first two registers.
	localparam logic [ndag_pkg::RegIdxBits-1:0] REG_STRIDE_A_LO = 3'd2;
	localparam logic [ndag_pkg::RegIdxBits-1:0] REG_STRIDE_A_HI = 3'd3;
	localparam logic [ndag_pkg::RegIdxBits-1:0] REG_STRIDE_B_LO = 3'd4;
	localparam logic [ndag_pkg::RegIdxBits-1:0] REG_STRIDE_B_HI = 3'd5;
	localparam logic [ndag_pkg::RegIdxBits-1:0] REG_STRIDE_C_LO = 3'd6;
	localparam logic [ndag_pkg::RegIdxBits-1:0] REG_STRIDE_C_HI = 3'd7;
	localparam int WATCHDOG_CYCLES = 5000;
	// Drain waits use a margin above the slowest item.
	localparam int SETTLE_CYCLES   = 200;

	typedef struct packed {
		ndag_pkg::op_t op;
		logic [31:0]   amount;
	} cmd_t;

	typedef struct packed {
		logic [95:0] offsets; // {offset_c, offset_b, offset_a}
		logic        wrapped;
	} addr_beat_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [39:0]                     s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [95:0]                     m_tdata;
	logic                            m_tuser;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [ndag_pkg::RegIdxBits-1:0] cfg_index;
	logic [63:0]                     cfg_data;

	nd_coordinate_address_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Predictor state: the register file and the mixed-radix coordinate.
	logic [63:0]  shadow_regs [ndag_pkg::NumRegs];
	logic [15:0]  coord [ndag_pkg::NumDims];
	cmd_t         cmd_q [$];
	addr_beat_t   offsets_q [$];
	int           errors;
	bit           idle_on;
	int           stall_cnt;
	int           gap_cnt;
	int           quiet_cnt;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned radix_of(int d);
		logic [15:0] s;
		s = shadow_regs[ndag_pkg::RegDimSizes][16*d +: 16];
		return (s == 16'd0) ? 64'd1 : {48'd0, s};
	endfunction

	function automatic logic [31:0] tensor_offset(int t);
		logic [31:0] acc;
		logic [31:0] c;
		logic [31:0] stride;
		acc = '0;
		for (int d = 0; d < ndag_pkg::NumDims; d++) begin
			c      = shadow_regs[ndag_pkg::RegBroadcast][4*t + d] ? 32'd0 : {16'd0, coord[d]};
			stride = shadow_regs[2 + 2*t + d/2][32*(d%2) +: 32];
			acc    = acc + c * stride;
		end
		return acc;
	endfunction

	// Applies one operation to the coordinate and returns the beat it must produce.
	function automatic addr_beat_t advance_coord(cmd_t cmd);
		addr_beat_t      r;
		longint unsigned n;
		longint unsigned s;
		bit              carried;
		r.wrapped = 1'b0;
		n = {32'd0, cmd.amount};
		case (cmd.op)
			ndag_pkg::OP_SET: begin
				for (int d = 0; d < ndag_pkg::NumDims; d++) begin
					s = radix_of(d);
					coord[d] = 16'(n % s);
					n = n / s;
				end
				r.wrapped = (n != 0);
			end
			ndag_pkg::OP_INC: begin
				// A digit at or beyond its last value clears and carries on.
				carried = 1'b1;
				for (int d = 0; d < ndag_pkg::NumDims; d++) begin
					if (carried) begin
						s = radix_of(d);
						if ({48'd0, coord[d]} < s - 1) begin
							coord[d] = coord[d] + 16'd1;
							carried  = 1'b0;
						end else begin
							coord[d] = '0;
						end
					end
				end
				r.wrapped = carried;
			end
			ndag_pkg::OP_ADVANCE: begin
				for (int d = 0; d < ndag_pkg::NumDims; d++) begin
					s = radix_of(d);
					n = n + {48'd0, coord[d]};
					coord[d] = 16'(n % s);
					n = n / s;
				end
				r.wrapped = (n != 0);
			end
			default: ; // unused code keeps the coordinate
		endcase
		r.offsets = {tensor_offset(2), tensor_offset(1), tensor_offset(0)};
		return r;
	endfunction

	// Input driver: presents queued items, predicting each one as it is accepted.
	always @(posedge clk or negedge arst_n) begin : drive_items
		bit   fire;
		cmd_t cmd;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_cnt  <= 0;
		end else begin
			fire = s_tvalid && s_tready;
			if (fire) begin
				cmd.op     = ndag_pkg::op_t'(s_tdata[1:0]);
				cmd.amount = s_tdata[33:2];
				offsets_q  = {offsets_q, advance_coord(cmd)};
			end
			if (fire || !s_tvalid) begin
				if (gap_cnt > 0) begin
					gap_cnt  <= gap_cnt - 1;
					s_tvalid <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					cmd      = cmd_q.pop_front();
					s_tdata  <= {6'd0, cmd.amount, cmd.op};
					s_tvalid <= 1'b1;
					// Bursts of idle cycles between beats, in some stretches only.
					if (idle_on && $urandom_range(0, 3) == 0)
						gap_cnt <= $urandom_range(1, 3);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random backpressure on m_tready.
	always @(posedge clk or negedge arst_n) begin : check_results
		addr_beat_t exp_beat;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			stall_cnt <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (offsets_q.size() == 0) begin
					$display("%0t: unexpected result beat %h wrapped %b", $time, m_tdata, m_tuser);
					errors++;
				end else begin
					exp_beat = offsets_q.pop_front();
					for (int t = 0; t < 3; t++)
						if (m_tdata[32*t +: 32] !== exp_beat.offsets[32*t +: 32]) begin
							$display("%0t: offset of tensor %0d expected %h actual %h", $time, t,
								exp_beat.offsets[32*t +: 32], m_tdata[32*t +: 32]);
							errors++;
						end
					if (m_tuser !== exp_beat.wrapped) begin
						$display("%0t: wrapped expected %b actual %b", $time,
							exp_beat.wrapped, m_tuser);
						errors++;
					end
				end
			end
			if (stall_cnt > 0) begin
				stall_cnt <= stall_cnt - 1;
				m_tready  <= 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				stall_cnt <= $urandom_range(0, 2);
				m_tready  <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: counts cycles in which no beat moves on any channel.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cnt <= 0;
		end else if (quiet_cnt >= WATCHDOG_CYCLES) begin
			$display("nd_coordinate_address_generator test failed");
			$finish;
		end else begin
			quiet_cnt <= quiet_cnt + 1;
		end
	end

	// Writes one register; the shadow copy is updated on the handshake.
	task automatic write_reg(logic [ndag_pkg::RegIdxBits-1:0] idx, logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_regs[idx] = (idx == ndag_pkg::RegBroadcast) ? (value & 64'hFFF) : value;
	endtask

	// Waits until the sender is empty and every result beat has arrived,
	// then lets the block finish any work before configuration changes.
	task automatic drain();
		do @(posedge clk);
		while (cmd_q.size() > 0 || s_tvalid || offsets_q.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_cmd(ndag_pkg::op_t op, logic [31:0] amount);
		cmd_t c;
		c.op     = op;
		c.amount = amount;
		cmd_q    = {cmd_q, c};
	endtask

	function automatic logic [31:0] pick_stride();
		case ($urandom_range(0, 5))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return $urandom_range(0, 64);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_size();
		case ($urandom_range(0, 9))
			0:       return 16'd0;       // counts as size one
			1:       return 16'hFFFF;
			2:       return 16'($urandom);
			default: return 16'($urandom_range(1, 5));
		endcase
	endfunction

	task automatic random_config();
		logic [63:0] sizes;
		for (int d = 0; d < ndag_pkg::NumDims; d++)
			sizes[16*d +: 16] = pick_size();
		write_reg(ndag_pkg::RegDimSizes, sizes);
		write_reg(ndag_pkg::RegBroadcast, 64'($urandom_range(0, 4095)));
		for (int r = 2; r < ndag_pkg::NumRegs; r++)
			write_reg(ndag_pkg::RegIdxBits'(r), {pick_stride(), pick_stride()});
	endtask

	// Single steps, the most frequent item, carry through the small dimensions; plus jumps.
	task automatic random_items(int count);
		int sel;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 19);
			if (sel < 8)
				queue_cmd(ndag_pkg::OP_INC, $urandom);
			else if (sel < 13)
				queue_cmd(ndag_pkg::OP_SET,
					($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 300)) : 32'($urandom));
			else if (sel < 18)
				queue_cmd(ndag_pkg::OP_ADVANCE,
					($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 40)) : 32'($urandom));
			else
				queue_cmd(ndag_pkg::OP_NONE, $urandom);
		end
	endtask

	initial begin
		errors    = 0;
		idle_on   = 1'b1;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		for (int r = 0; r < ndag_pkg::NumRegs; r++)
			shadow_regs[r] = '0;
		shadow_regs[ndag_pkg::RegDimSizes] = 64'h0001_0001_0001_0001;
		for (int d = 0; d < ndag_pkg::NumDims; d++)
			coord[d] = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset shape: every size is one, so any nonzero index or step wraps.
		queue_cmd(ndag_pkg::OP_INC, 32'd0);
		queue_cmd(ndag_pkg::OP_SET, 32'd1);
		drain();

		// Shape 2 x 3 x 4 x 5 (120 points) with extreme strides.
		write_reg(ndag_pkg::RegDimSizes, 64'h0005_0004_0003_0002);
		write_reg(ndag_pkg::RegBroadcast, 64'h0A5);
		write_reg(REG_STRIDE_A_LO, 64'h0000_0008_0000_0004);
		write_reg(REG_STRIDE_A_HI, 64'h0000_0100_0000_0020);
		write_reg(REG_STRIDE_B_LO, 64'h8000_0000_7FFF_FFFF);
		write_reg(REG_STRIDE_B_HI, 64'hFFFF_FFFF_8000_0000);
		write_reg(REG_STRIDE_C_LO, 64'h0000_0001_FFFF_FFFF);
		write_reg(REG_STRIDE_C_HI, 64'h7FFF_FFFF_0000_0003);
		queue_cmd(ndag_pkg::OP_SET, 32'd0);
		queue_cmd(ndag_pkg::OP_SET, 32'd120);        // index equal to the volume wraps
		queue_cmd(ndag_pkg::OP_SET, 32'hFFFF_FFFF);
		queue_cmd(ndag_pkg::OP_SET, 32'd117);
		queue_cmd(ndag_pkg::OP_INC, 32'hFFFF_FFFF);
		queue_cmd(ndag_pkg::OP_INC, 32'd0);
		queue_cmd(ndag_pkg::OP_INC, 32'd0);          // carry out of the top dimension
		queue_cmd(ndag_pkg::OP_ADVANCE, 32'd0);
		queue_cmd(ndag_pkg::OP_ADVANCE, 32'd7);
		queue_cmd(ndag_pkg::OP_ADVANCE, 32'hFFFF_FFFF);
		queue_cmd(ndag_pkg::OP_NONE, 32'hFFFF_FFFF); // unused code only reports offsets
		queue_cmd(ndag_pkg::OP_SET, 32'd119);
		drain();

		// Shrink the shape under a large coordinate, with a zero size field.
		write_reg(ndag_pkg::RegDimSizes, 64'h0002_0002_0000_0001);
		write_reg(ndag_pkg::RegBroadcast, 64'hF00);
		queue_cmd(ndag_pkg::OP_INC, 32'd0);
		queue_cmd(ndag_pkg::OP_SET, 32'd119);
		drain();
		write_reg(ndag_pkg::RegDimSizes, 64'h0002_0001_0002_0002);
		queue_cmd(ndag_pkg::OP_ADVANCE, 32'd5);
		queue_cmd(ndag_pkg::OP_SET, 32'd3);
		drain();

		// Random shapes and strides; the last phase runs without idle cycles.
		for (int p = 0; p < 8; p++) begin
			random_config();
			if (p == 7)
				idle_on = 1'b0;
			random_items(92);
			drain();
		end

		if (errors == 0)
			$display("nd_coordinate_address_generator test passed");
		else
			$display("nd_coordinate_address_generator test failed");
		$finish;
	end
endmodule
